>>> rtl/sbda_pkg.sv
package sbda_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 32;

  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned CHAR_W  = 6;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 6'd57;

  // A decimal digit of 5 or more is raised by 3 before each doubling.
  localparam logic [DIGIT_W-1:0] DABBLE_LIMIT = 4'd5;
  localparam logic [DIGIT_W-1:0] DABBLE_ADD   = 4'd3;

endpackage

>>> rtl/sbda_dabble.sv
module sbda_dabble import sbda_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int unsigned NUM_DIGITS  = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [VALUE_WIDTH-1:0]        mag_i,
  output logic                          busy_o,
  output logic                          done_o,
  output logic [NUM_DIGITS*DIGIT_W-1:0] bcd_o
);

  localparam int unsigned BcdW = NUM_DIGITS * DIGIT_W;
  localparam int unsigned CntW = $clog2(VALUE_WIDTH + 1);

  logic [VALUE_WIDTH-1:0] bin_q, bin_d;
  logic [BcdW-1:0]        bcd_q, bcd_d;
  logic [BcdW-1:0]        adj;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic                   done_q, done_d;

  // One double-dabble step: adjust every digit, then shift the whole
  // digit and binary word left by one bit.
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_q[i*DIGIT_W +: DIGIT_W] >= DABBLE_LIMIT) begin
        adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W] + DABBLE_ADD;
      end else begin
        adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      bin_d = mag_i;
      bcd_d = '0;
      cnt_d = CntW'(VALUE_WIDTH);
    end else if (cnt_q != '0) begin
      bin_d  = {bin_q[VALUE_WIDTH-2:0], 1'b0};
      bcd_d  = {adj[BcdW-2:0], bin_q[VALUE_WIDTH-1]};
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign busy_o = (cnt_q != '0);
  assign done_o = done_q;
  assign bcd_o  = bcd_q;

endmodule

>>> rtl/signed_binary_to_decimal_ascii.sv
// A value is converted bit by bit from the input beat, then its minus sign, if any, and
// its digits are sent through the registered output; leading zeros are dropped. Input
// ready is high only in the idle state, so a new value is taken only after every digit
// position of the last one has been scanned, and the output side can stall the scan.
// Reset is asynchronous and active low; it clears the sequencer and output valid.
module signed_binary_to_decimal_ascii import sbda_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  logic [((VALUE_WIDTH+7)/8)*8-1:0]     s_axis_tdata_i,  // [VALUE_WIDTH-1:0] value
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  output logic [7:0]                           m_axis_tdata_o,  // [5:0] character
  output logic                                 m_axis_tlast_o
);

  localparam int unsigned NumDigits = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
  localparam int unsigned BcdW      = NumDigits * DIGIT_W;
  localparam int unsigned RemW      = $clog2(NumDigits + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_SIGN,
    S_EMIT
  } state_e;

  state_e                 state_q;
  logic                   neg_q;
  logic                   started_q;
  logic [RemW-1:0]        rem_q;
  logic [BcdW-1:0]        dig_q;
  logic                   out_valid_q;
  logic [CHAR_W-1:0]      out_char_q, out_char_d;
  logic                   out_last_q, out_last_d;

  logic [VALUE_WIDTH-1:0] value;
  logic [VALUE_WIDTH-1:0] mag;
  logic                   in_beat;
  logic                   dab_busy;
  logic                   dab_done;
  logic [BcdW-1:0]        dab_bcd;
  logic                   slot_free;
  logic [DIGIT_W-1:0]     nib;
  logic                   show;
  logic                   out_load;
  logic                   step;

  assign value   = s_axis_tdata_i[VALUE_WIDTH-1:0];
  assign mag     = value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;
  assign in_beat = s_axis_tvalid_i && s_axis_tready_o;

  sbda_dabble #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .NUM_DIGITS  (NumDigits)
  ) u_dabble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_beat),
    .mag_i   (mag),
    .busy_o  (dab_busy),
    .done_o  (dab_done),
    .bcd_o   (dab_bcd)
  );

  assign slot_free = !out_valid_q || m_axis_tready_i;
  assign nib       = dig_q[BcdW-1 -: DIGIT_W];
  // Leading zeros are dropped, but the units digit always prints.
  assign show      = started_q || (nib != '0) || (rem_q == RemW'(1));
  assign step      = (state_q == S_EMIT) && (!show || slot_free);

  always_comb begin
    out_load   = 1'b0;
    out_char_d = CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, nib};
    out_last_d = (rem_q == RemW'(1));
    if (state_q == S_SIGN && slot_free) begin
      out_load   = 1'b1;
      out_char_d = CHAR_MINUS;
      out_last_d = 1'b0;
    end else if (step && show) begin
      out_load = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      neg_q       <= 1'b0;
      started_q   <= 1'b0;
      rem_q       <= '0;
      dig_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_beat) begin
            neg_q   <= value[VALUE_WIDTH-1];
            state_q <= S_CONV;
          end
        end
        S_CONV: begin
          if (dab_done) begin
            dig_q     <= dab_bcd;
            rem_q     <= RemW'(NumDigits);
            started_q <= 1'b0;
            state_q   <= neg_q ? S_SIGN : S_EMIT;
          end
        end
        S_SIGN: begin
          if (slot_free) begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (step) begin
            dig_q <= {dig_q[BcdW-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            rem_q <= rem_q - 1'b1;
            if (show) begin
              started_q <= 1'b1;
            end
            if (rem_q == RemW'(1)) begin
              state_q <= S_IDLE;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_char_q <= out_char_d;
      out_last_q <= out_last_d;
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(8-CHAR_W){1'b0}}, out_char_q};
  assign m_axis_tlast_o  = out_last_q;

  a_ready_engine_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !dab_busy)
    else $error("input ready while the conversion unit is busy");

  a_done_in_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dab_done |-> (state_q == S_CONV))
    else $error("conversion finished outside the convert state");

  a_last_is_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |-> (out_char_q != CHAR_MINUS))
    else $error("final character of a value is a minus sign");

  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      (out_char_q == CHAR_MINUS) || (out_char_q >= CHAR_ZERO && out_char_q <= CHAR_NINE))
    else $error("output character is not a digit or minus sign");

  a_sign_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SIGN && slot_free) |=> (state_q == S_EMIT && !started_q))
    else $error("minus sign not followed by the digit scan");

endmodule

>>> test/testbench.sv
module testbench;
  import sbda_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned VW        = VALUE_WIDTH_DEF;
  localparam int unsigned IN_W      = ((VW + 7) / 8) * 8;
  localparam int          WATCHDOG  = 2000;
  localparam int          DRAIN     = 2 * VW;
  localparam int          N_RANDOM  = 80;
  localparam int          N_QUIET   = 20;
  localparam int          MAX_SHOWN = 10;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } text_char_t;

  class decimal_text_scoreboard;
    text_char_t pending_chars[$];
    int         mismatches;

    function new();
      pending_chars.delete();
      mismatches = 0;
    endfunction

    // Expands one accepted value into the characters of its decimal text.
    function void note_value(logic [VW-1:0] value);
      logic [VW-1:0]     magnitude;
      logic [DIGIT_W-1:0] digits[$];
      text_char_t        entry;
      magnitude = value[VW-1] ? -value : value;
      if (magnitude == '0) begin
        entry.code = CHAR_ZERO;
        entry.last = 1'b1;
        pending_chars.push_back(entry);
        return;
      end
      while (magnitude != '0) begin
        digits.push_front(DIGIT_W'(magnitude % 10));
        magnitude = magnitude / 10;
      end
      if (value[VW-1]) begin
        entry.code = CHAR_MINUS;
        entry.last = 1'b0;
        pending_chars.push_back(entry);
      end
      foreach (digits[i]) begin
        entry.code = CHAR_ZERO + CHAR_W'(digits[i]);
        entry.last = (i == digits.size() - 1);
        pending_chars.push_back(entry);
      end
    endfunction

    function void check_char(logic [CHAR_W-1:0] code, logic last);
      text_char_t want;
      if (pending_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("unexpected character: code %0d last %0b", code, last);
        return;
      end
      want = pending_chars.pop_front();
      if (code !== want.code || last !== want.last) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("character mismatch: expected code %0d last %0b, got code %0d last %0b",
                   want.code, want.last, code, last);
      end
    endfunction

    function int outstanding();
      return pending_chars.size();
    endfunction
  endclass

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            s_axis_tvalid_i = 1'b0;
  logic            s_axis_tready_o;
  logic [IN_W-1:0] s_axis_tdata_i = '0;   // [VW-1:0] value
  logic            m_axis_tvalid_o;
  logic            m_axis_tready_i = 1'b1;
  logic [7:0]      m_axis_tdata_o;        // [5:0] character
  logic            m_axis_tlast_o;

  decimal_text_scoreboard text_sb = new();
  bit                     quiet = 1'b0;
  bit                     calm = 1'b0;
  int                     idle_cycles = 0;
  int                     stall_left = 0;

  signed_binary_to_decimal_ascii #(
    .VALUE_WIDTH(VW)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      text_sb.note_value(s_axis_tdata_i[VW-1:0]);
    end
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      text_sb.check_char(m_axis_tdata_o[CHAR_W-1:0], m_axis_tlast_o);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles <= 0;
    end else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Calm stretches switch idling off on both sides for a while.
  always @(negedge clk_i) begin
    if ($urandom_range(39) == 0) calm = ~calm;
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready_i <= 1'b0;
      end else if (!quiet && !calm && $urandom_range(3) == 0) begin
        stall_left = $urandom_range(1, 3) - 1;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // Called at a falling edge; returns at a falling edge with tvalid still high.
  task automatic send_value(input logic [VW-1:0] value);
    int gap;
    if (!quiet && !calm && $urandom_range(3) == 0) begin
      gap = $urandom_range(1, 3);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= IN_W'(value);
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
  endtask

  // Except for raw random words, picks a digit count first so short and long texts are equally common.
  function automatic logic [VW-1:0] random_value();
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mag;
    int              ndig;
    bit              negative;
    if ($urandom_range(3) == 0) return VW'($urandom);
    ndig = $urandom_range(1, 10);
    negative = 1'($urandom_range(1));
    lo = (ndig == 1) ? 0 : 64'd1;
    for (int i = 1; i < ndig; i++) lo = lo * 10;
    hi = (ndig == 1) ? 9 : lo * 10 - 1;
    if (negative && hi > 64'd2147483648) hi = 64'd2147483648;
    if (!negative && hi > 64'd2147483647) hi = 64'd2147483647;
    mag = lo + ($urandom_range(0, 32'(hi - lo)));
    return negative ? -VW'(mag) : VW'(mag);
  endfunction

  logic [VW-1:0] directed_values[] = '{
    32'd0, 32'd1, -32'd1, 32'd9, -32'd9, 32'd10, -32'd10, 32'd99, 32'd100,
    32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000, 32'd999999999,
    -32'd1000000000, 32'h5555_5555, 32'hAAAA_AAAA, 32'd123456789, -32'd987654321,
    32'd5
  };

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_values[i]) send_value(directed_values[i]);
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM - N_QUIET) quiet = 1'b1;
      send_value(random_value());
    end
    s_axis_tvalid_i <= 1'b0;

    while (text_sb.outstanding() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);

    if (text_sb.mismatches == 0 && text_sb.outstanding() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
